/* rtl/slps_pkg.sv */
package slps_pkg;

    typedef enum logic [3:0] {
        MODE_OFF      = 4'd0,
        MODE_ON       = 4'd1,
        MODE_2HZ      = 4'd2,
        MODE_1HZ      = 4'd3,
        MODE_HALFHZ   = 4'd4,
        MODE_FLICKON  = 4'd5,
        MODE_FLICKOFF = 4'd6,
        MODE_LONGON   = 4'd7,
        MODE_LONGOFF  = 4'd8,
        MODE_OFF1S    = 4'd9
    } mode_t;

    typedef enum logic [3:0] {
        CODE_OFF       = 4'd0,
        CODE_UNINIT    = 4'd1,
        CODE_SETUP     = 4'd2,
        CODE_NORMAL    = 4'd3,
        CODE_LEARN     = 4'd4,
        CODE_BOOT      = 4'd5,
        CODE_MEMFAULT  = 4'd6,
        CODE_FATAL     = 4'd7,
        CODE_RESETWARN = 4'd8,
        CODE_MSGRX     = 4'd9,
        CODE_MSGACTED  = 4'd10,
        CODE_TXERR     = 4'd11,
        CODE_RXERR     = 4'd12
    } status_t;

    typedef enum logic {
        CMD_POLL   = 1'b0,
        CMD_STATUS = 1'b1
    } cmd_t;

    localparam int TICK_W = 8;

    localparam logic [TICK_W-1:0] HALF_2HZ    = 8'd25;
    localparam logic [TICK_W-1:0] HALF_1HZ    = 8'd50;
    localparam logic [TICK_W-1:0] HALF_HALFHZ = 8'd100;
    localparam logic [TICK_W-1:0] FULL_2HZ    = 8'd50;
    localparam logic [TICK_W-1:0] FULL_1HZ    = 8'd100;
    localparam logic [TICK_W-1:0] FULL_HALFHZ = 8'd200;
    localparam logic [TICK_W-1:0] FLICK_TICKS = 8'd25;
    localparam logic [TICK_W-1:0] LONG_TICKS  = 8'd50;
    localparam logic [TICK_W-1:0] OFF1S_TICKS = 8'd100;

    typedef struct packed {
        logic       command;
        logic       tick_elapsed;
        logic [3:0] status_code;
    } in_item_t;

    typedef struct packed {
        logic       led_on;
        logic [3:0] led_mode;
    } out_item_t;

endpackage

/* rtl/slps_engine.sv */
module slps_engine
    import slps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step_en,
    input  in_item_t  item,
    output out_item_t result
);

    mode_t             mode_reg, mode_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic              led_level_reg, led_level_next;
    logic [TICK_W-1:0] tick_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_OFF;
            tick_count_reg <= '0;
            led_level_reg  <= 1'b0;
        end else if (step_en) begin
            mode_reg       <= mode_next;
            tick_count_reg <= tick_count_next;
            led_level_reg  <= led_level_next;
        end
    end

    assign tick_inc = item.tick_elapsed ? tick_count_reg + TICK_W'(1) : tick_count_reg;

    always_comb begin
        mode_next       = mode_reg;
        tick_count_next = tick_count_reg;
        led_level_next  = led_level_reg;
        if (cmd_t'(item.command) == CMD_STATUS) begin
            case (status_t'(item.status_code))
                CODE_OFF:                             mode_next = MODE_OFF;
                CODE_UNINIT:                          mode_next = MODE_HALFHZ;
                CODE_SETUP:                           mode_next = MODE_1HZ;
                CODE_NORMAL, CODE_LEARN, CODE_BOOT:   mode_next = MODE_ON;
                CODE_MEMFAULT, CODE_FATAL,
                CODE_RESETWARN:                       mode_next = MODE_2HZ;
                CODE_MSGRX:                           mode_next = MODE_FLICKOFF;
                CODE_MSGACTED:                        mode_next = MODE_LONGOFF;
                CODE_TXERR, CODE_RXERR:               mode_next = MODE_OFF1S;
                default:                              mode_next = mode_reg;
            endcase
        end else begin
            tick_count_next = tick_inc;
            case (mode_reg)
                MODE_ON: begin
                    led_level_next  = 1'b1;
                    tick_count_next = '0;
                end
                MODE_OFF: begin
                    led_level_next  = 1'b0;
                    tick_count_next = '0;
                end
                MODE_2HZ: begin
                    led_level_next = (tick_inc >= HALF_2HZ);
                    if (tick_inc >= FULL_2HZ) tick_count_next = '0;
                end
                MODE_1HZ: begin
                    led_level_next = (tick_inc >= HALF_1HZ);
                    if (tick_inc >= FULL_1HZ) tick_count_next = '0;
                end
                MODE_HALFHZ: begin
                    led_level_next = (tick_inc >= HALF_HALFHZ);
                    if (tick_inc >= FULL_HALFHZ) tick_count_next = '0;
                end
                MODE_FLICKON: begin
                    led_level_next = 1'b1;
                    if (tick_inc >= FLICK_TICKS) begin
                        tick_count_next = '0;
                        mode_next       = MODE_OFF;
                    end
                end
                MODE_FLICKOFF: begin
                    led_level_next = 1'b0;
                    if (tick_inc >= FLICK_TICKS) begin
                        tick_count_next = '0;
                        mode_next       = MODE_ON;
                    end
                end
                MODE_LONGON: begin
                    led_level_next = 1'b1;
                    if (tick_inc >= LONG_TICKS) begin
                        tick_count_next = '0;
                        mode_next       = MODE_OFF;
                    end
                end
                MODE_LONGOFF: begin
                    led_level_next = 1'b0;
                    if (tick_inc >= LONG_TICKS) begin
                        tick_count_next = '0;
                        mode_next       = MODE_ON;
                    end
                end
                MODE_OFF1S: begin
                    led_level_next = 1'b0;
                    if (tick_inc >= OFF1S_TICKS) begin
                        tick_count_next = '0;
                        mode_next       = MODE_ON;
                    end
                end
                default: begin
                    led_level_next = led_level_reg;
                end
            endcase
        end
    end

    assign result.led_on   = led_level_next;
    assign result.led_mode = mode_next;

    a_status_holds_led: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.command == CMD_STATUS |=> $stable(led_level_reg))
        else $error("status item changed LED level");

    a_idle_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(tick_count_reg) && $stable(mode_reg))
        else $error("state changed without an item");

    a_steady_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.command == CMD_POLL && (mode_reg == MODE_ON || mode_reg == MODE_OFF)
        |=> tick_count_reg == '0)
        else $error("steady mode left counter running");

    a_flash_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.command == CMD_POLL && mode_reg == MODE_2HZ
        |=> tick_count_reg < FULL_2HZ)
        else $error("2 Hz counter passed its period");

endmodule

/* rtl/status_led_pattern_sequencer.sv */
// Status LED sequencer. Each item is a status command (sets the LED mode from a
// status code) or a poll (advances the 10 ms tick count and updates the LED).
// One result item per input item, one item per clock sustained while m_ready
// holds: an item is held in the input register, is decoded against the mode
// and tick state, and its result is registered in the output register.
// The input side keeps accepting while a result waits, until both stages fill.
module status_led_pattern_sequencer
    import slps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      advance;
    out_item_t result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (advance) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_data_reg <= s_data;
        if (advance) out_data_reg <= result;
    end

    slps_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_data_reg),
        .result  (result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* tb/tb_status_led_pattern_sequencer.sv */
`timescale 1ns / 1ps

module tb_status_led_pattern_sequencer;
    import slps_pkg::*;

    localparam int NUM_ITEMS   = 1750;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 60;
    localparam int HOLD_AT     = 600;
    localparam int DRAIN_WAIT  = 8;

    class led_pattern_scoreboard;
        mode_t          mode;
        logic [7:0]     ticks;
        logic           led;
        out_item_t      pending_leds[$];
        int             errors;
        int             checked;
        int             n_status;
        int             n_polls;
        int             n_unknown;
        logic [9:0]     modes_seen;

        function new();
            mode       = MODE_OFF;
            ticks      = '0;
            led        = 1'b0;
            errors     = 0;
            checked    = 0;
            n_status   = 0;
            n_polls    = 0;
            n_unknown  = 0;
            modes_seen = '0;
        endfunction

        function void flash(logic [7:0] half, logic [7:0] full);
            led = (ticks / half) != 8'd0;
            if (ticks >= full)
                ticks = '0;
        endfunction

        function void one_shot(logic level, logic [7:0] limit, mode_t next_mode);
            led = level;
            if (ticks >= limit) begin
                ticks = '0;
                mode  = next_mode;
            end
        endfunction

        function void accept_command(in_item_t it);
            out_item_t res;
            if (it.command == CMD_STATUS) begin
                n_status++;
                case (status_t'(it.status_code))
                    CODE_OFF:                              mode = MODE_OFF;
                    CODE_UNINIT:                           mode = MODE_HALFHZ;
                    CODE_SETUP:                            mode = MODE_1HZ;
                    CODE_NORMAL, CODE_LEARN, CODE_BOOT:    mode = MODE_ON;
                    CODE_MEMFAULT, CODE_FATAL, CODE_RESETWARN:
                                                           mode = MODE_2HZ;
                    CODE_MSGRX:                            mode = MODE_FLICKOFF;
                    CODE_MSGACTED:                         mode = MODE_LONGOFF;
                    CODE_TXERR, CODE_RXERR:                mode = MODE_OFF1S;
                    default:                               n_unknown++;
                endcase
            end else begin
                n_polls++;
                if (it.tick_elapsed)
                    ticks = ticks + 8'd1;
                case (mode)
                    MODE_ON: begin
                        led   = 1'b1;
                        ticks = '0;
                    end
                    MODE_OFF: begin
                        led   = 1'b0;
                        ticks = '0;
                    end
                    MODE_2HZ:      flash(HALF_2HZ, FULL_2HZ);
                    MODE_1HZ:      flash(HALF_1HZ, FULL_1HZ);
                    MODE_HALFHZ:   flash(HALF_HALFHZ, FULL_HALFHZ);
                    MODE_FLICKON:  one_shot(1'b1, FLICK_TICKS, MODE_OFF);
                    MODE_FLICKOFF: one_shot(1'b0, FLICK_TICKS, MODE_ON);
                    MODE_LONGON:   one_shot(1'b1, LONG_TICKS, MODE_OFF);
                    MODE_LONGOFF:  one_shot(1'b0, LONG_TICKS, MODE_ON);
                    MODE_OFF1S:    one_shot(1'b0, OFF1S_TICKS, MODE_ON);
                    default: ;
                endcase
            end
            res.led_on   = led;
            res.led_mode = mode;
            pending_leds.push_back(res);
        endfunction

        function void check_led(out_item_t got);
            out_item_t exp;
            if (pending_leds.size() == 0) begin
                $error("unexpected result: led_on=%0d led_mode=%0d", got.led_on, got.led_mode);
                errors++;
                return;
            end
            exp = pending_leds.pop_front();
            checked++;
            if (got.led_mode < 10)
                modes_seen[got.led_mode] = 1'b1;
            if (got.led_on !== exp.led_on) begin
                $error("led_on: expected %0d, got %0d", exp.led_on, got.led_on);
                errors++;
            end
            if (got.led_mode !== exp.led_mode) begin
                $error("led_mode: expected %0d, got %0d", exp.led_mode, got.led_mode);
                errors++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    led_pattern_scoreboard sb;
    bit steady;
    int sent;
    int idle_cycles;

    status_led_pattern_sequencer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic offer_item(input in_item_t it);
        while (!steady && $urandom_range(0, 99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.accept_command(it);
        sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_leds.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_status(input logic [3:0] code, input logic tick);
        in_item_t it;
        it.command      = CMD_STATUS;
        it.tick_elapsed = tick;
        it.status_code  = code;
        offer_item(it);
    endtask

    task automatic send_poll(input logic tick, input logic [3:0] junk);
        in_item_t it;
        it.command      = CMD_POLL;
        it.tick_elapsed = tick;
        it.status_code  = junk;
        offer_item(it);
    endtask

    // results
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_led(m_data);
    end

    // receiver, with one long hold-off to back up the pipeline
    initial begin
        int hold;
        bit held;
        hold    = 0;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (!held && sb.checked >= HOLD_AT) begin
                held = 1'b1;
                hold = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 38);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int seq;
        int npolls;
        in_item_t it;
        sb          = new();
        seq         = 0;
        sent        = 0;
        steady      = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle polls, then every status code incl. unknown ones
        send_poll(1'b0, 4'h0);
        send_poll(1'b1, 4'hF);
        for (int c = 0; c < 16; c++) begin
            send_status(4'(c), c[0]);
            if (c[0])
                send_poll(c[1], c[1] ? 4'hF : 4'h0);
        end
        send_status(CODE_MSGRX, 1'b0);
        wait_drained();

        while (sent < NUM_ITEMS) begin
            seq++;
            steady = (seq >= 5 && seq < 9);
            if (seq == 12)
                wait_drained();
            if ($urandom_range(0, 4) == 0) begin
                repeat (10) begin
                    it.command      = 1'($urandom_range(0, 1));
                    it.tick_elapsed = 1'($urandom_range(0, 1));
                    it.status_code  = 4'($urandom_range(0, 15));
                    offer_item(it);
                end
            end else begin
                if ($urandom_range(0, 6) == 0)
                    send_status(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                else
                    send_status(4'($urandom_range(0, 12)), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                    npolls = $urandom_range(150, 240);
                else
                    npolls = $urandom_range(5, 70);
                repeat (npolls)
                    send_poll($urandom_range(0, 9) != 0, 4'($urandom_range(0, 15)));
            end
        end
        steady = 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("checked %0d results: %0d status commands (%0d unknown codes), %0d polls",
                 sb.checked, sb.n_status, sb.n_unknown, sb.n_polls);
        $display("LED modes seen in results (bit per mode): %b", sb.modes_seen);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
